// ===== rtl/ccfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared constants, types and the CRC-16/KERMIT byte fold for the COBS frame
// receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  // Stuffed bytes taken per frame before further bytes are dropped (8..63).
  localparam int RAW_BUFFER_BYTES  = 32;
  // Largest payload after the four-byte message id (1..8).
  localparam int MAX_PAYLOAD_BYTES = 8;

  localparam logic [15:0] CRC_POLY        = 16'h8408;
  localparam logic [7:0]  FRAME_DELIMITER = 8'h00;
  // A COBS code byte of this value is not followed by an implied zero.
  localparam logic [7:0]  COBS_CODE_FULL  = 8'hFF;

  // Per-frame overhead: message id plus trailing CRC.
  localparam int ID_BYTES  = 4;
  localparam int CRC_BYTES = 2;

  typedef struct packed {
    logic        valid;
    logic [31:0] msg_id;
    logic [3:0]  payload_length;
    logic [63:0] payload;
  } frame_result_t;

  // One byte folded into a reflected CRC-16 with polynomial 0x8408.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage : ccfr_pkg
`default_nettype wire

// ===== rtl/ccfr_frame_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccfr_frame_core
// Per-byte COBS decode, two-byte lag, running CRC and field collection. Gives
// a frame verdict when the delimiter word is taken.
// ----------------------------------------------------------------------------
module ccfr_frame_core
  import ccfr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_take,
  input  wire logic [7:0]    rx_byte,
  output frame_result_t      result
);

  localparam logic [5:0] RAW_LIMIT     = 6'(RAW_BUFFER_BYTES);
  localparam logic [5:0] COUNT_MAX     = 6'd63;
  localparam logic [5:0] LAG_DEPTH     = 6'(CRC_BYTES);
  localparam logic [5:0] ID_LIMIT      = 6'(ID_BYTES);
  localparam logic [5:0] DATA_LIMIT    = 6'(ID_BYTES + MAX_PAYLOAD_BYTES);
  localparam logic [5:0] MIN_DECODED   = 6'(ID_BYTES + CRC_BYTES);

  logic [5:0]  raw_count_r,       raw_count_nxt;
  logic [7:0]  cobs_remaining_r,  cobs_remaining_nxt;
  logic        zero_pending_r,    zero_pending_nxt;
  logic [5:0]  decoded_count_r,   decoded_count_nxt;
  logic [15:0] lag_bytes_r,       lag_bytes_nxt;
  logic [15:0] crc_running_r,     crc_running_nxt;
  logic [31:0] id_collect_r,      id_collect_nxt;
  logic [63:0] payload_collect_r, payload_collect_nxt;
  logic        frame_bad_r,       frame_bad_nxt;

  logic        is_delim;
  logic        push;
  logic [7:0]  push_byte;
  logic [7:0]  leaving;
  logic [5:0]  data_index;
  logic [5:0]  payload_index;
  logic [5:0]  length_full;

  assign is_delim      = (rx_byte == FRAME_DELIMITER);
  assign leaving       = lag_bytes_r[7:0];
  assign data_index    = decoded_count_r - LAG_DEPTH;
  assign payload_index = data_index - ID_LIMIT;
  assign length_full   = decoded_count_r - MIN_DECODED;

  always_comb begin
    raw_count_nxt       = raw_count_r;
    cobs_remaining_nxt  = cobs_remaining_r;
    zero_pending_nxt    = zero_pending_r;
    decoded_count_nxt   = decoded_count_r;
    lag_bytes_nxt       = lag_bytes_r;
    crc_running_nxt     = crc_running_r;
    id_collect_nxt      = id_collect_r;
    payload_collect_nxt = payload_collect_r;
    frame_bad_nxt       = frame_bad_r;
    push                = 1'b0;
    push_byte           = rx_byte;

    result.valid          = 1'b0;
    result.msg_id         = id_collect_r;
    result.payload_length = length_full[3:0];
    result.payload        = payload_collect_r;

    if (byte_take) begin
      if (is_delim) begin
        result.valid = (raw_count_r != 6'd0) && (cobs_remaining_r == 8'd0) &&
                       !frame_bad_r && (decoded_count_r >= MIN_DECODED) &&
                       (crc_running_r == lag_bytes_r);
        // Every delimiter starts a fresh frame.
        raw_count_nxt       = '0;
        cobs_remaining_nxt  = '0;
        zero_pending_nxt    = 1'b0;
        decoded_count_nxt   = '0;
        lag_bytes_nxt       = '0;
        crc_running_nxt     = '0;
        id_collect_nxt      = '0;
        payload_collect_nxt = '0;
        frame_bad_nxt       = 1'b0;
      end else if (raw_count_r < RAW_LIMIT) begin
        raw_count_nxt = raw_count_r + 6'd1;
        if (cobs_remaining_r == 8'd0) begin
          // Code byte: emit the zero implied by the previous block.
          push               = zero_pending_r;
          push_byte          = 8'h00;
          zero_pending_nxt   = (rx_byte != COBS_CODE_FULL);
          cobs_remaining_nxt = rx_byte - 8'd1;
        end else begin
          push               = 1'b1;
          cobs_remaining_nxt = cobs_remaining_r - 8'd1;
        end
      end
    end

    if (push) begin
      if (decoded_count_r >= LAG_DEPTH) begin
        crc_running_nxt = crc_fold(crc_running_r, leaving);
        if (data_index < ID_LIMIT) begin
          id_collect_nxt[8*data_index[1:0] +: 8] =
            id_collect_r[8*data_index[1:0] +: 8] | leaving;
        end else if (data_index < DATA_LIMIT) begin
          payload_collect_nxt[8*payload_index[2:0] +: 8] =
            payload_collect_r[8*payload_index[2:0] +: 8] | leaving;
        end else begin
          frame_bad_nxt = 1'b1;
        end
      end
      lag_bytes_nxt = {push_byte, lag_bytes_r[15:8]};
      if (decoded_count_r < COUNT_MAX) begin
        decoded_count_nxt = decoded_count_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_count_r       <= '0;
      cobs_remaining_r  <= '0;
      zero_pending_r    <= 1'b0;
      decoded_count_r   <= '0;
      lag_bytes_r       <= '0;
      crc_running_r     <= '0;
      id_collect_r      <= '0;
      payload_collect_r <= '0;
      frame_bad_r       <= 1'b0;
    end else begin
      raw_count_r       <= raw_count_nxt;
      cobs_remaining_r  <= cobs_remaining_nxt;
      zero_pending_r    <= zero_pending_nxt;
      decoded_count_r   <= decoded_count_nxt;
      lag_bytes_r       <= lag_bytes_nxt;
      crc_running_r     <= crc_running_nxt;
      id_collect_r      <= id_collect_nxt;
      payload_collect_r <= payload_collect_nxt;
      frame_bad_r       <= frame_bad_nxt;
    end
  end

endmodule : ccfr_frame_core
`default_nettype wire

// ===== rtl/cobs_crc_frame_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver
// Result: a frame's result is registered and presented in the cycle after its delimiter word.
// Throughput: one link word per cycle; the frame state is updated in one pass.
// The only hold-off is a full result register whose word is stalled.
// Reset: synchronous, active low; clears frame state and the result valid.
// Result payload registers are not reset.
// ----------------------------------------------------------------------------
// Link words arrive on the input channel. Nonzero words are COBS-decoded as
// they come; a zero word closes the frame. The last two decoded bytes are the
// received CRC-16/KERMIT, low byte first, and are held back in a two-byte lag
// so that only true frame data is folded into the running CRC. A good frame
// of at least four data bytes yields one result word carrying the message id
// and up to eight payload bytes; bad, short, malformed or oversize frames are
// dropped silently.
// ----------------------------------------------------------------------------
module cobs_crc_frame_receiver
  import ccfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_msg_id,
  output logic [3:0]       out_payload_length,
  output logic [63:0]      out_payload
);

  frame_result_t frame_result;
  logic          in_take;
  logic          out_valid_r;
  logic [31:0]   out_msg_id_r;
  logic [3:0]    out_payload_length_r;
  logic [63:0]   out_payload_r;

  // A new word is refused only while the result register holds a word that
  // the receiver is not taking this cycle; a drain and a load may coincide.
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  ccfr_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (in_take),
    .rx_byte   (in_rx_byte),
    .result    (frame_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frame_result.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload is loaded only with a good frame verdict.
  always_ff @(posedge clk) begin
    if (frame_result.valid) begin
      out_msg_id_r         <= frame_result.msg_id;
      out_payload_length_r <= frame_result.payload_length;
      out_payload_r        <= frame_result.payload;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_msg_id         = out_msg_id_r;
  assign out_payload_length = out_payload_length_r;
  assign out_payload        = out_payload_r;

endmodule : cobs_crc_frame_receiver
`default_nettype wire

// ===== tb/tb_cobs_crc_frame_receiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cobs_crc_frame_receiver
// Self-checking bench for the COBS frame receiver with CRC-16/KERMIT check.
// Link words are built from whole frames, most of them well formed with
// random content and the rest corrupted, cut short, oversize or plain noise.
// A frame tracker follows every accepted word and queues the result that each
// delimiter should yield; every result word is checked against it in order.
// ----------------------------------------------------------------------------
module tb_cobs_crc_frame_receiver;
  import ccfr_pkg::*;

  // Roughly how many link words the random part sends before it stops.
  localparam int unsigned WORD_TARGET = 1750;
  // Cycles without a single accepted word before the run is abandoned. The
  // slowest correct stretch is a sender gap plus a receiver stall, and this
  // leaves a wide margin over it.
  localparam int unsigned IDLE_LIMIT  = 2000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_msg_id;
  logic [3:0]  out_payload_length;
  logic [63:0] out_payload;

  cobs_crc_frame_receiver dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_msg_id         (out_msg_id),
    .out_payload_length (out_payload_length),
    .out_payload        (out_payload)
  );

  // Follows the receiver word by word: COBS decoding, the two-byte lag that
  // holds back the trailing CRC, the running CRC and the id/payload collection.
  // Each delimiter that closes a good frame queues the result word it owes.
  class frame_tracker;
    typedef struct packed {
      logic [31:0] msg_id;
      logic [3:0]  payload_length;
      logic [63:0] payload;
    } frame_word_t;

    int unsigned raw_taken;
    int unsigned block_left;
    bit          zero_owed;
    int unsigned decoded;
    logic [15:0] lag;
    logic [15:0] crc;
    logic [31:0] id_acc;
    logic [63:0] payload_acc;
    bit          oversize;

    frame_word_t owed_frames[$];
    int unsigned errors;
    int unsigned frames_closed;
    int unsigned frames_kept;
    int unsigned frames_checked;

    function new();
      restart_frame();
    endfunction

    // Reflected CRC-16, one byte at a time, least significant bit first.
    static function logic [15:0] kermit_step(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void restart_frame();
      raw_taken   = 0;
      block_left  = 0;
      zero_owed   = 1'b0;
      decoded     = 0;
      lag         = '0;
      crc         = '0;
      id_acc      = '0;
      payload_acc = '0;
      oversize    = 1'b0;
    endfunction

    // A decoded byte enters the lag; the one pushed out of it is frame data.
    function void take_decoded(logic [7:0] b);
      int unsigned k;
      logic [7:0]  leaving;
      if (decoded >= 2) begin
        leaving = lag[7:0];
        k       = decoded - 2;
        crc     = kermit_step(crc, leaving);
        if (k < ID_BYTES) begin
          id_acc[8*k +: 8] = leaving;
        end else if (k < ID_BYTES + MAX_PAYLOAD_BYTES) begin
          payload_acc[8*(k-ID_BYTES) +: 8] = leaving;
        end else begin
          oversize = 1'b1;
        end
      end
      lag = {b, lag[15:8]};
      if (decoded < 63) decoded++;
    endfunction

    function void note_word(logic [7:0] w);
      frame_word_t owed;
      if (w == FRAME_DELIMITER) begin
        frames_closed++;
        if (raw_taken > 0 && block_left == 0 && !oversize &&
            decoded >= ID_BYTES + CRC_BYTES && crc == lag) begin
          owed.msg_id         = id_acc;
          owed.payload_length = 4'(decoded - ID_BYTES - CRC_BYTES);
          owed.payload        = payload_acc;
          owed_frames.push_back(owed);
          frames_kept++;
        end
        restart_frame();
        return;
      end
      // Once the raw buffer is full the rest of the frame is dropped.
      if (raw_taken >= RAW_BUFFER_BYTES || raw_taken >= 63) return;
      raw_taken++;
      if (block_left == 0) begin
        if (zero_owed) take_decoded(8'h00);
        zero_owed  = (w != COBS_CODE_FULL);
        block_left = w - 1;
      end else begin
        take_decoded(w);
        block_left--;
      end
    endfunction

    function void check_result(logic [31:0] id, logic [3:0] len, logic [63:0] pl);
      frame_word_t want;
      if (owed_frames.size() == 0) begin
        $display("%0t: result word with no frame owed: id %h, length %0d, payload %h",
                 $time, id, len, pl);
        errors++;
        return;
      end
      want = owed_frames.pop_front();
      frames_checked++;
      if (want.msg_id !== id) begin
        $display("%0t: msg_id expected %h, got %h", $time, want.msg_id, id);
        errors++;
      end
      if (want.payload_length !== len) begin
        $display("%0t: payload_length expected %0d, got %0d",
                 $time, want.payload_length, len);
        errors++;
      end
      if (want.payload !== pl) begin
        $display("%0t: payload expected %h, got %h", $time, want.payload, pl);
        errors++;
      end
    endfunction
  endclass

  frame_tracker tracker = new();

  // Frame contents before stuffing, the stuffed form, and the words to send.
  logic [7:0]  frame_data[$];
  logic [7:0]  stuffed[$];
  logic [7:0]  link_words[$];

  // In a burst a side neither idles nor stalls, so back-to-back words occur.
  bit          in_burst  = 1'b0;
  bit          out_burst = 1'b0;
  int unsigned words_sent  = 0;
  int unsigned frames_sent = 0;
  int unsigned idle_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("cobs_crc_frame_receiver: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one link word after a random gap and waits until it is taken.
  // Handshake signals are sampled just after the edge, which still shows the
  // values the receiver saw at that edge.
  task automatic send_word(input logic [7:0] w);
    int unsigned gap;
    if ($urandom_range(39, 0) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(17, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= w;
    do @(posedge clk); while (in_stall);
    tracker.note_word(w);
    words_sent++;
  endtask

  task automatic send_link();
    while (link_words.size() != 0) send_word(link_words.pop_front());
  endtask

  // Random frame body: a share of zero bytes makes COBS blocks short.
  function automatic void fill_data(int unsigned n, int unsigned zero_pct);
    frame_data = {};
    repeat (n) begin
      if ($urandom_range(99, 0) < zero_pct) frame_data.push_back(8'h00);
      else frame_data.push_back(8'($urandom_range(255, 1)));
    end
  endfunction

  // Appends the CRC, low byte first; a bad one has a single bit flipped.
  function automatic void seal_frame(bit crc_ok);
    logic [15:0] c;
    c = '0;
    foreach (frame_data[i]) c = frame_tracker::kermit_step(c, frame_data[i]);
    if (!crc_ok) c = c ^ (16'(1) << $urandom_range(15, 0));
    frame_data.push_back(c[7:0]);
    frame_data.push_back(c[15:8]);
  endfunction

  // Canonical COBS stuffing of the frame data.
  function automatic void stuff_frame();
    int unsigned code_at;
    int unsigned run;
    stuffed = {};
    code_at = 0;
    run     = 1;
    stuffed.push_back(8'h00);
    foreach (frame_data[i]) begin
      if (frame_data[i] == 8'h00) begin
        stuffed[code_at] = 8'(run);
        code_at = stuffed.size();
        stuffed.push_back(8'h00);
        run = 1;
      end else begin
        stuffed.push_back(frame_data[i]);
        run++;
        if (run == 255) begin
          stuffed[code_at] = COBS_CODE_FULL;
          code_at = stuffed.size();
          stuffed.push_back(8'h00);
          run = 1;
        end
      end
    end
    stuffed[code_at] = 8'(run);
  endfunction

  function automatic void post_frame();
    foreach (stuffed[i]) link_words.push_back(stuffed[i]);
    link_words.push_back(FRAME_DELIMITER);
  endfunction

  // Result side: each result word is held off for a random number of cycles
  // in which one is actually waiting, so the stall really presses on the
  // receiver and, through its full result register, on the input channel.
  initial begin
    int unsigned hold;
    int unsigned seen;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(29, 0) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(17, 0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        seen = 0;
        while (seen < hold) begin
          @(posedge clk);
          if (out_valid) seen++;
        end
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      tracker.check_result(out_msg_id, out_payload_length, out_payload);
    end
  end

  initial begin
    int unsigned pick;
    int unsigned idx;
    int unsigned keep;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames. An empty frame, a delimiter inside an open block, and
    // a frame of a single decoded byte must all be dropped.
    link_words.push_back(FRAME_DELIMITER);
    link_words.push_back(8'h02);
    link_words.push_back(FRAME_DELIMITER);
    link_words.push_back(8'h02);
    link_words.push_back(8'h07);
    link_words.push_back(FRAME_DELIMITER);
    // All-zero id with no payload: every stuffed word is a code of one.
    frame_data = '{8'h00, 8'h00, 8'h00, 8'h00};
    seal_frame(1'b1);
    stuff_frame();
    post_frame();
    // All-ones id with the longest payload.
    frame_data = {};
    repeat (ID_BYTES + MAX_PAYLOAD_BYTES) frame_data.push_back(8'hFF);
    seal_frame(1'b1);
    stuff_frame();
    post_frame();
    send_link();
    frames_sent += 5;

    // Random frames: mostly well formed, the rest broken in various ways.
    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(99, 0);
      case ($urandom_range(2, 0))
        0:       idx = 0;
        1:       idx = 15;
        default: idx = 50;
      endcase
      if (pick < 65) begin
        fill_data(ID_BYTES + $urandom_range(MAX_PAYLOAD_BYTES, 0), idx);
        seal_frame(1'b1);
        stuff_frame();
        post_frame();
      end else if (pick < 72) begin
        // Wrong CRC.
        fill_data(ID_BYTES + $urandom_range(MAX_PAYLOAD_BYTES, 0), idx);
        seal_frame(1'b0);
        stuff_frame();
        post_frame();
      end else if (pick < 77) begin
        // Too short to hold an id.
        fill_data($urandom_range(ID_BYTES - 1, 0), idx);
        seal_frame(1'b1);
        stuff_frame();
        post_frame();
      end else if (pick < 82) begin
        // Payload beyond the limit, with a correct CRC.
        fill_data(ID_BYTES + MAX_PAYLOAD_BYTES + $urandom_range(6, 1), idx);
        seal_frame(1'b1);
        stuff_frame();
        post_frame();
      end else if (pick < 87) begin
        // One stuffed word replaced, removed or added.
        fill_data(ID_BYTES + $urandom_range(MAX_PAYLOAD_BYTES, 0), idx);
        seal_frame(1'b1);
        stuff_frame();
        idx = $urandom_range(stuffed.size() - 1, 0);
        case ($urandom_range(2, 0))
          0:       stuffed[idx] = 8'($urandom_range(255, 1));
          1:       stuffed.delete(idx);
          default: stuffed.insert(idx, 8'($urandom_range(255, 1)));
        endcase
        post_frame();
      end else if (pick < 92) begin
        // Cut short before the delimiter.
        fill_data(ID_BYTES + $urandom_range(MAX_PAYLOAD_BYTES, 0), idx);
        seal_frame(1'b1);
        stuff_frame();
        keep = $urandom_range(stuffed.size() - 1, 1);
        while (stuffed.size() > keep) void'(stuffed.pop_back());
        post_frame();
      end else if (pick < 96) begin
        // Noise, long enough at times to fill the raw buffer; a leading full
        // code gives a block with no implied zero.
        stuffed = {};
        if ($urandom_range(1, 0) == 0) stuffed.push_back(COBS_CODE_FULL);
        repeat ($urandom_range(45, 1)) begin
          stuffed.push_back(8'($urandom_range(255, 1)));
        end
        post_frame();
      end else begin
        // Runs of empty frames.
        repeat ($urandom_range(3, 1)) link_words.push_back(FRAME_DELIMITER);
      end
      send_link();
      frames_sent++;
    end
    in_valid <= 1'b0;

    // Drain the owed results, then allow for the registered result stage.
    while (tracker.owed_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (out_valid && out_stall) begin
      $display("%0t: result word left waiting with no frame owed: id %h",
               $time, out_msg_id);
      tracker.errors++;
    end

    $display("Sent %0d link words in %0d frames; %0d delimiters seen.",
             words_sent, frames_sent, tracker.frames_closed);
    $display("%0d good frames checked, %0d frames dropped as bad, short or oversize.",
             tracker.frames_checked, tracker.frames_closed - tracker.frames_kept);
    if (tracker.errors == 0) begin
      $display("cobs_crc_frame_receiver: match");
    end else begin
      $display("cobs_crc_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ccfr_pkg.sv
rtl/ccfr_frame_core.sv
rtl/cobs_crc_frame_receiver.sv
tb/tb_cobs_crc_frame_receiver.sv
